FILE: design/swsum_pkg.sv
// ---------------------------------------------------------------------------
// swsum_pkg
// Shared widths, the window reset value and the command word passed from the
// classifier to the accumulator of the sliding window sum core.
// ---------------------------------------------------------------------------
package swsum_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int SUM_W          = 22;
   localparam int WIN_W          = 7;
   localparam int DEF_MAX_WINDOW = 64;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(3);

   // one classified beat: what the accumulator has to do with it
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W-1:0] old_sample;
      logic                sub_en;
      logic                add_en;
      logic                emit;
      logic                last;
   } op_type;

endpackage

FILE: design/swsum_front.sv
// ---------------------------------------------------------------------------
// swsum_front
// Accepts sample beats, keeps the window length, ring write pointer and fill
// count, stores samples in the ring and fetches the sample leaving the window.
// ---------------------------------------------------------------------------
module swsum_front #(
   parameter int MAX_WINDOW = swsum_pkg::DEF_MAX_WINDOW
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [swsum_pkg::WIN_W-1:0]    csr_window_len,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [swsum_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                           req_end_of_array,
   output logic                           op_valid,
   output swsum_pkg::op_type              op,
   input  logic                           op_stall
);
   import swsum_pkg::*;

   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int DW = (AW + 1 > WIN_W) ? AW + 1 : WIN_W;

   logic [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];

   logic [WIN_W-1:0]    window_ff;
   logic [AW-1:0]       wp_ff, wp_in;
   logic [WIN_W-1:0]    cnt_ff, cnt_in;
   logic                s1_valid_ff, s1_valid_in;
   op_type              s1_op_ff, s1_op_in;
   logic [SAMPLE_W-1:0] rd_data_ff;

   logic [WIN_W-1:0]    win_k;
   logic [AW-1:0]       old_addr;
   logic [DW-1:0]       wp_ext, k_ext;
   logic                accept, window_full, store_en;

   assign req_stall = s1_valid_ff && op_stall;
   assign accept    = req_valid && !req_stall;

   // window length saturated at the ring depth
   always_comb begin
      if (int'(window_ff) > MAX_WINDOW) begin
         win_k = WIN_W'(MAX_WINDOW);
      end else begin
         win_k = window_ff;
      end
   end

   always_comb begin
      wp_ext = DW'(wp_ff);
      k_ext  = DW'(win_k);
      if (wp_ext >= k_ext) begin
         old_addr = AW'(wp_ext - k_ext);
      end else begin
         old_addr = AW'(wp_ext + DW'(MAX_WINDOW) - k_ext);
      end
   end

   always_comb begin
      window_full = cnt_ff >= win_k;
      store_en    = win_k != '0;
      wp_in       = wp_ff;
      cnt_in      = cnt_ff;
      s1_op_in.sample     = req_sample;
      s1_op_in.old_sample = '0;
      s1_op_in.sub_en     = 1'b0;
      s1_op_in.add_en     = 1'b0;
      s1_op_in.emit       = 1'b0;
      s1_op_in.last       = req_end_of_array;
      if (store_en) begin
         s1_op_in.sub_en = window_full;
         s1_op_in.add_en = 1'b1;
         if (!window_full) begin
            cnt_in = cnt_ff + 1'b1;
         end
         s1_op_in.emit = (cnt_in >= win_k) || req_end_of_array;
         if (wp_ff == AW'(MAX_WINDOW - 1)) begin
            wp_in = '0;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
      end
      if (req_end_of_array) begin
         wp_in  = '0;
         cnt_in = '0;
      end
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (!op_stall) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= WINDOW_RESET;
         wp_ff       <= '0;
         cnt_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            window_ff <= csr_window_len;
         end
         if (accept) begin
            wp_ff  <= wp_in;
            cnt_ff <= cnt_in;
         end
         s1_valid_ff <= s1_valid_in;
      end
   end

   // ring: at most one write, one registered read per beat
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff   <= s1_op_in;
         rd_data_ff <= ring_mem[old_addr];
         if (store_en) begin
            ring_mem[wp_ff] <= req_sample;
         end
      end
   end

   assign op_valid = s1_valid_ff;

   always_comb begin
      op            = s1_op_ff;
      op.old_sample = rd_data_ff;
   end

endmodule

FILE: design/swsum_queue.sv
// ---------------------------------------------------------------------------
// swsum_queue
// Short FIFO of classified beats between the classifier and the accumulator.
// ---------------------------------------------------------------------------
module swsum_queue #(
   parameter int DEPTH = swsum_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  swsum_pkg::op_type push_op,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output swsum_pkg::op_type head_op
);
   import swsum_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   op_type         slot_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]  count_ff;
   logic           do_push, do_pop;

   assign full       = count_ff == CW'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_op    = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

FILE: design/swsum_back.sv
// ---------------------------------------------------------------------------
// swsum_back
// Accumulator: applies at most one add and one subtract per beat to the running
// total and registers the window sum for the result channel.
// ---------------------------------------------------------------------------
module swsum_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  swsum_pkg::op_type           head_op,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [swsum_pkg::SUM_W-1:0] rsp_window_sum,
   output logic                        rsp_last_sum
);
   import swsum_pkg::*;

   logic [SUM_W-1:0] total_ff, total_in;
   logic [SUM_W-1:0] sum_sub, sum_add;
   logic [SUM_W-1:0] old_ext, new_ext;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0] rsp_sum_ff;
   logic             rsp_last_ff;
   logic             out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   // beats that produce no result drain even while the output is held
   assign pop      = head_valid && (!head_op.emit || out_free);

   always_comb begin
      old_ext = {{(SUM_W - SAMPLE_W){head_op.old_sample[SAMPLE_W-1]}}, head_op.old_sample};
      new_ext = {{(SUM_W - SAMPLE_W){head_op.sample[SAMPLE_W-1]}}, head_op.sample};
      sum_sub = head_op.sub_en ? total_ff - old_ext : total_ff;
      sum_add = head_op.add_en ? sum_sub + new_ext : sum_sub;
      total_in = head_op.last ? '0 : sum_add;
   end

   always_comb begin
      if (pop && head_op.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            total_ff <= total_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_op.emit) begin
         rsp_sum_ff  <= sum_add;
         rsp_last_ff <= head_op.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_sum = rsp_sum_ff;
   assign rsp_last_sum   = rsp_last_ff;

endmodule

FILE: design/sliding_window_sum_core.sv
// path: beat -> front register -> command queue -> accumulator result register
// throughput: one sample beat per cycle while the queue is not full, set by one ring
//   write, one ring read and one add/subtract in the accumulator per beat
// reset: synchronous; window length returns to 3, pointer, count and total clear
// ring contents are not cleared; the fill count keeps stale entries from being read
// ---------------------------------------------------------------------------
// sliding_window_sum_core
// Moving boxcar sum over arrays of signed samples, with a classifier front,
// a short command queue and an accumulator back end.
// ---------------------------------------------------------------------------
module sliding_window_sum_core #(
   parameter int MAX_WINDOW = swsum_pkg::DEF_MAX_WINDOW
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [swsum_pkg::WIN_W-1:0]    csr_window_len,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [swsum_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                           req_end_of_array,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [swsum_pkg::SUM_W-1:0]    rsp_window_sum,
   output logic                           rsp_last_sum
);
   import swsum_pkg::*;

   logic   op_valid, q_full, head_valid, pop;
   op_type op, head_op;

   swsum_front #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_window_len   (csr_window_len),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_end_of_array (req_end_of_array),
      .op_valid         (op_valid),
      .op               (op),
      .op_stall         (q_full)
   );

   swsum_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (op_valid),
      .push_op    (op),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   swsum_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_op        (head_op),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_window_sum (rsp_window_sum),
      .rsp_last_sum   (rsp_last_sum)
   );

endmodule
